### src/cffdt_pkg.sv
// Shared types, constants and helpers of the DICT token decoder.
package cffdt_pkg;

  localparam int MANTISSA_DIGITS_DEF = 18;
  localparam int MANT_W              = 60;
  localparam int EXP_W               = 14;
  localparam int COUNT_W             = 6;
  localparam int QDEPTH              = 2;
  localparam int QPTR_W              = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W              = $clog2(QDEPTH + 1);

  localparam logic [EXP_W-1:0]   EXP_LIMIT   = EXP_W'(9999);
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(63);

  // lead byte values
  localparam logic [7:0] LB_ESCAPE   = 8'd12;
  localparam logic [7:0] LB_INT16    = 8'd28;
  localparam logic [7:0] LB_INT32    = 8'd29;
  localparam logic [7:0] LB_REAL     = 8'd30;
  localparam logic [7:0] LB_POS_BASE = 8'd247;
  localparam logic [7:0] LB_NEG_BASE = 8'd251;
  localparam logic [7:0] SHORT_BIAS  = 8'd139;
  localparam logic [7:0] TWO_BIAS    = 8'd108;
  localparam logic [3:0] ESC_PREFIX  = 4'hC;

  // real nibble codes
  localparam logic [3:0] NIB_POINT   = 4'hA;
  localparam logic [3:0] NIB_POS_EXP = 4'hB;
  localparam logic [3:0] NIB_NEG_EXP = 4'hC;
  localparam logic [3:0] NIB_SKIP    = 4'hD;
  localparam logic [3:0] NIB_MINUS   = 4'hE;
  localparam logic [3:0] NIB_END     = 4'hF;

  typedef enum logic [1:0] {
    TK_OPERATOR = 2'd0,
    TK_INTEGER  = 2'd1,
    TK_REAL     = 2'd2,
    TK_ERROR    = 2'd3
  } token_kind_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ESCAPE = 2'd1,
    PH_INT    = 2'd2,
    PH_REAL   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    LC_OP       = 3'd0,
    LC_ESC      = 3'd1,
    LC_SHORT    = 3'd2,
    LC_MULTI    = 3'd3,
    LC_REAL     = 3'd4,
    LC_RESERVED = 3'd5
  } lead_class_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    lead_class_e lead_class;
    logic [2:0]  int_len;
  } entry_t;

  // 10^digits - 1, capped to the accumulator width
  function automatic logic [MANT_W-1:0] mant_limit(int digits);
    logic [63:0] v;
    v = 64'd1;
    for (int i = 0; i < 19; i++) begin
      if (i < digits) v = v * 64'd10;
    end
    v = v - 64'd1;
    if (v > {{(64-MANT_W){1'b0}}, {MANT_W{1'b1}}}) v = {{(64-MANT_W){1'b0}}, {MANT_W{1'b1}}};
    return v[MANT_W-1:0];
  endfunction

endpackage

### src/cffdt_if.sv
// Handshake channels: raw DICT bytes in, decoded tokens out.
interface cffdt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cffdt_token_if;
  logic               valid;
  logic               ready;
  logic [1:0]         token_kind;
  logic [11:0]        operator_code;
  logic signed [31:0] int_value;
  logic [59:0]        real_whole;
  logic [59:0]        real_fraction;
  logic [5:0]         fraction_digits;
  logic [13:0]        exponent_magnitude;
  logic               exponent_negative;
  logic               value_negative;
  logic               overflow;

  modport source (output valid, output token_kind, output operator_code, output int_value,
                  output real_whole, output real_fraction, output fraction_digits,
                  output exponent_magnitude, output exponent_negative,
                  output value_negative, output overflow, input ready);
  modport sink   (input valid, input token_kind, input operator_code, input int_value,
                  input real_whole, input real_fraction, input fraction_digits,
                  input exponent_magnitude, input exponent_negative,
                  input value_negative, input overflow, output ready);
endinterface

### src/cffdt_front.sv
// Front end: classifies each byte as a lead byte and queues it for the parser.
module cffdt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  cffdt_byte_if.sink      dict_i,
  output cffdt_pkg::entry_t entry_o,
  output logic            entry_valid_o,
  input  logic            entry_pop_i
);
  import cffdt_pkg::*;

  entry_t             q_mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  entry_t             new_entry;
  logic               push, pop;

  // classification only matters when the parser is idle; done for every byte
  always_comb begin
    new_entry.data_byte  = dict_i.data_byte;
    new_entry.last_byte  = dict_i.last_byte;
    new_entry.lead_class = LC_OP;
    new_entry.int_len    = 3'd1;
    if (dict_i.data_byte == LB_ESCAPE) begin
      new_entry.lead_class = LC_ESC;
    end else if (dict_i.data_byte inside {[8'd0:8'd27], 8'd31}) begin
      new_entry.lead_class = LC_OP;
    end else if (dict_i.data_byte inside {[8'd32:8'd246]}) begin
      new_entry.lead_class = LC_SHORT;
    end else if (dict_i.data_byte == LB_REAL) begin
      new_entry.lead_class = LC_REAL;
    end else if (dict_i.data_byte == 8'd255) begin
      new_entry.lead_class = LC_RESERVED;
    end else begin
      new_entry.lead_class = LC_MULTI;
      if (dict_i.data_byte == LB_INT16)      new_entry.int_len = 3'd2;
      else if (dict_i.data_byte == LB_INT32) new_entry.int_len = 3'd4;
      else                                   new_entry.int_len = 3'd1;
    end
  end

  assign dict_i.ready  = (count_q != QCNT_W'(QDEPTH));
  assign push          = dict_i.valid && dict_i.ready;
  assign entry_valid_o = (count_q != '0);
  assign pop           = entry_pop_i && entry_valid_o;
  assign entry_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop)      count_d = count_q + QCNT_W'(1);
    else if (pop && !push) count_d = count_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= new_entry;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("byte queue over capacity");

endmodule

### src/cffdt_back.sv
// Back end: token parser with real accumulators and the output register.
module cffdt_back #(
  parameter int MANTISSA_DIGITS = cffdt_pkg::MANTISSA_DIGITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cffdt_pkg::entry_t entry_i,
  input  logic              entry_valid_i,
  output logic              entry_pop_o,
  cffdt_token_if.source     token_o
);
  import cffdt_pkg::*;

  localparam logic [MANT_W-1:0] MantLimit = mant_limit(MANTISSA_DIGITS);

  typedef struct packed {
    logic [MANT_W-1:0]  whole;
    logic [MANT_W-1:0]  frac;
    logic [COUNT_W-1:0] fcount;
    logic [EXP_W-1:0]   expo;
    logic               mk_frac;
    logic               mk_pos;
    logic               mk_neg;
    logic               mk_minus;
    logic               mk_ovf;
    logic               done;
  } real_st_t;

  typedef struct packed {
    token_kind_e        kind;
    logic [11:0]        op_code;
    logic [31:0]        int_val;
    logic [MANT_W-1:0]  whole;
    logic [MANT_W-1:0]  frac;
    logic [COUNT_W-1:0] fcount;
    logic [EXP_W-1:0]   expo;
    logic               exp_neg;
    logic               val_neg;
    logic               ovf;
  } token_t;

  // acc*10 + d saturating at lim
  function automatic logic [MANT_W:0] push_mant(logic [MANT_W-1:0] acc, logic [3:0] d,
                                                 logic [MANT_W-1:0] lim);
    logic [MANT_W+3:0] t;
    t = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{MANT_W{1'b0}}, d};
    if (t > {4'd0, lim}) return {1'b1, lim};
    return {1'b0, t[MANT_W-1:0]};
  endfunction

  function automatic real_st_t real_nibble(real_st_t s, logic [3:0] n);
    real_st_t         r;
    logic [MANT_W:0]  pm;
    logic [EXP_W+2:0] te;
    r  = s;
    pm = '0;
    te = '0;
    case (n)
      NIB_POINT:   r.mk_frac  = 1'b1;
      NIB_POS_EXP: r.mk_pos   = 1'b1;
      NIB_NEG_EXP: r.mk_neg   = 1'b1;
      NIB_SKIP:    ;
      NIB_MINUS:   r.mk_minus = 1'b1;
      NIB_END:     r.done     = 1'b1;
      default: begin
        if (s.mk_pos || s.mk_neg) begin
          te = ({3'd0, s.expo} << 3) + ({3'd0, s.expo} << 1) + {{(EXP_W-1){1'b0}}, n};
          if (te > {3'd0, EXP_LIMIT}) begin
            r.expo   = EXP_LIMIT;
            r.mk_ovf = 1'b1;
          end else begin
            r.expo = te[EXP_W-1:0];
          end
        end else if (s.mk_frac) begin
          pm     = push_mant(s.frac, n, MantLimit);
          r.frac = pm[MANT_W-1:0];
          if (pm[MANT_W]) r.mk_ovf = 1'b1;
          if (s.fcount == COUNT_LIMIT) r.mk_ovf = 1'b1;
          else r.fcount = s.fcount + COUNT_W'(1);
        end else begin
          pm      = push_mant(s.whole, n, MantLimit);
          r.whole = pm[MANT_W-1:0];
          if (pm[MANT_W]) r.mk_ovf = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  phase_e     phase_q, phase_d;
  logic [2:0] rem_q, rem_d;
  logic [7:0] lead_q, lead_d;
  logic [31:0] iacc_q, iacc_d;
  real_st_t   rs_q, rs_d;
  token_t     out_q, res;
  logic       out_valid_q;
  logic       advance, emit;

  real_st_t   rs_hi, rs_lo, rs_in;
  logic [31:0] iacc_n;
  logic [2:0]  rem_n;
  logic [10:0] two_mag;
  logic [7:0]  b;

  assign b           = entry_i.data_byte;
  assign advance     = entry_valid_i && (!out_valid_q || token_o.ready);
  assign entry_pop_o = advance;

  always_comb begin
    rs_in      = rs_q;
    rs_in.done = 1'b0;
    rs_hi      = real_nibble(rs_in, b[7:4]);
    rs_lo      = real_nibble(rs_hi, b[3:0]);
  end

  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    lead_d  = lead_q;
    iacc_d  = iacc_q;
    rs_d    = rs_q;
    res     = '0;
    emit    = 1'b0;
    iacc_n  = {iacc_q[23:0], b};
    rem_n   = (rem_q != 3'd0) ? rem_q - 3'd1 : 3'd0;
    two_mag = '0;
    if (advance) begin
      case (phase_q)
        PH_ESCAPE: begin
          emit        = 1'b1;
          res.kind    = TK_OPERATOR;
          res.op_code = {ESC_PREFIX, b};
        end
        PH_INT: begin
          iacc_d = iacc_n;
          rem_d  = rem_n;
          if (rem_n == 3'd0) begin
            emit     = 1'b1;
            res.kind = TK_INTEGER;
            if (lead_q inside {[8'd247:8'd250]}) begin
              two_mag     = {1'b0, 2'(lead_q - LB_POS_BASE), b} + {3'd0, TWO_BIAS};
              res.int_val = {21'd0, two_mag};
            end else if (lead_q inside {[8'd251:8'd254]}) begin
              two_mag     = {1'b0, 2'(lead_q - LB_NEG_BASE), b} + {3'd0, TWO_BIAS};
              res.int_val = 32'd0 - {21'd0, two_mag};
            end else if (lead_q == LB_INT16) begin
              res.int_val = {{16{iacc_n[15]}}, iacc_n[15:0]};
            end else begin
              res.int_val = iacc_n;
            end
          end else if (entry_i.last_byte) begin
            emit     = 1'b1;
            res.kind = TK_ERROR;
          end
        end
        PH_REAL: begin
          rs_d = rs_lo;
          if (rs_lo.done) begin
            emit        = 1'b1;
            res.kind    = TK_REAL;
            res.whole   = rs_lo.whole;
            res.frac    = rs_lo.frac;
            res.fcount  = rs_lo.fcount;
            res.expo    = rs_lo.expo;
            res.exp_neg = rs_lo.mk_neg;
            res.val_neg = rs_lo.mk_minus;
            res.ovf     = rs_lo.mk_ovf;
          end else if (entry_i.last_byte) begin
            emit     = 1'b1;
            res.kind = TK_ERROR;
          end
        end
        default: begin
          case (entry_i.lead_class)
            LC_OP: begin
              emit        = 1'b1;
              res.kind    = TK_OPERATOR;
              res.op_code = {4'd0, b};
            end
            LC_SHORT: begin
              emit        = 1'b1;
              res.kind    = TK_INTEGER;
              res.int_val = {24'd0, b} - {24'd0, SHORT_BIAS};
            end
            LC_RESERVED: begin
              emit     = 1'b1;
              res.kind = TK_ERROR;
            end
            default: begin
              if (entry_i.last_byte) begin
                emit     = 1'b1;
                res.kind = TK_ERROR;
              end else if (entry_i.lead_class == LC_ESC) begin
                phase_d = PH_ESCAPE;
              end else if (entry_i.lead_class == LC_REAL) begin
                phase_d = PH_REAL;
              end else begin
                lead_d  = b;
                iacc_d  = '0;
                rem_d   = entry_i.int_len;
                phase_d = PH_INT;
              end
            end
          endcase
        end
      endcase
      if (emit) begin
        phase_d = PH_IDLE;
        rem_d   = '0;
        lead_d  = '0;
        iacc_d  = '0;
        rs_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      rem_q       <= '0;
      lead_q      <= '0;
      iacc_q      <= '0;
      rs_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      lead_q  <= lead_d;
      iacc_q  <= iacc_d;
      rs_q    <= rs_d;
      if (token_o.ready) out_valid_q <= 1'b0;
      if (advance && emit) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) out_q <= res;
  end

  assign token_o.valid              = out_valid_q;
  assign token_o.token_kind         = out_q.kind;
  assign token_o.operator_code      = out_q.op_code;
  assign token_o.int_value          = $signed(out_q.int_val);
  assign token_o.real_whole         = out_q.whole;
  assign token_o.real_fraction      = out_q.frac;
  assign token_o.fraction_digits    = out_q.fcount;
  assign token_o.exponent_magnitude = out_q.expo;
  assign token_o.exponent_negative  = out_q.exp_neg;
  assign token_o.value_negative     = out_q.val_neg;
  assign token_o.overflow           = out_q.ovf;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_INT |-> rem_q != 3'd0)
    else $error("integer phase with no bytes outstanding");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rs_q.whole <= MantLimit && rs_q.frac <= MantLimit && rs_q.expo <= EXP_LIMIT)
    else $error("real accumulator above its limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_REAL |-> rs_q == '0)
    else $error("real accumulators not cleared outside a real");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == TK_ERROR |->
      out_q.op_code == '0 && out_q.int_val == '0 && out_q.whole == '0 &&
      out_q.frac == '0 && out_q.fcount == '0 && out_q.expo == '0 && !out_q.ovf)
    else $error("error token carries payload");

endmodule

### src/cff_dict_token_decoder_unit.sv
// Top level of the DICT token decoder: byte front end, queue and token parser.
// Usage:
//   dict_i carries one DICT byte per beat (data_byte, last_byte set on the
//   final byte available). token_o carries one token per beat: kind, then
//   operator code, integer value or the decimal parts of a real; fields not
//   belonging to the kind are zero. Operators, integers, reals and errors
//   (reserved lead byte, or the stream ending inside a token) each give one
//   beat; bytes in the middle of a token give none.
// Throughput: one byte per cycle, sustained, as long as token_o is taken.
// Path: an accepted byte is written into the two-entry byte queue and parsed
//   from its head when the parser advances; a token it completes is held in
//   the output register. Both nibbles of a real byte are folded into the
//   accumulators in the same cycle.
// Stall: while a token waits in the output register the parser holds; the
//   queue keeps taking bytes until its two entries are full.
// Reset: rst_ni is asynchronous, active low; the parser returns to idle with
//   all accumulators cleared and the queue and output register empty.
module cff_dict_token_decoder_unit #(
  parameter int MANTISSA_DIGITS = cffdt_pkg::MANTISSA_DIGITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cffdt_byte_if.sink    dict_i,
  cffdt_token_if.source token_o
);
  import cffdt_pkg::*;

  entry_t entry;
  logic   entry_valid;
  logic   entry_pop;

  cffdt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dict_i        (dict_i),
    .entry_o       (entry),
    .entry_valid_o (entry_valid),
    .entry_pop_i   (entry_pop)
  );

  cffdt_back #(
    .MANTISSA_DIGITS (MANTISSA_DIGITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (entry),
    .entry_valid_i (entry_valid),
    .entry_pop_o   (entry_pop),
    .token_o       (token_o)
  );

endmodule
